// ----- hdl/hfd_pkg.sv -----
// shared types, constants and the crc-8 byte step for the frame decoder
// no dependencies; compiled first
`default_nettype none

package hfd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_t;

  // byte position within a frame
  typedef logic [2:0] pos_t;

  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam pos_t       LAST_POS  = 3'd5;

  // frame byte positions
  localparam pos_t POS_TEMP_MSB = 3'd0;
  localparam pos_t POS_TEMP_LSB = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_MSB  = 3'd3;
  localparam pos_t POS_HUM_LSB  = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  // conversion constants
  localparam logic [12:0] TEMP_GAIN   = 13'd4375;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [9:0]  HUM_GAIN    = 10'd625;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hfd_in_if.sv -----
// input channel: one received frame byte per request
// depends on nothing but the handshake convention valid/ready
`default_nettype none

interface hfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- hdl/hfd_out_if.sv -----
// result channel: decoded temperature, humidity and status
// depends on hfd_pkg for the status type
`default_nettype none

interface hfd_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [14:0]     temperature_centi;
  logic [13:0]            humidity_centi;
  hfd_pkg::status_t       frame_status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output frame_status, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input frame_status, output ready);
endinterface

`default_nettype wire

// ----- hdl/hfd_scale.sv -----
// fixed-point conversion of the raw sensor words to hundredths
// depends on hfd_pkg for the gains and offset
`default_nettype none

module hfd_scale (
  input  wire logic [15:0]        temp_raw,
  input  wire logic [15:0]        hum_raw,
  output logic signed [14:0]      temp_centi,
  output logic [13:0]             hum_centi
);

  logic [28:0] temp_prod;
  logic [25:0] hum_prod;
  logic [15:0] temp_diff;

  // temperature: ((4375 * raw) >> 14) - 4500
  assign temp_prod  = {13'd0, temp_raw} * {16'd0, hfd_pkg::TEMP_GAIN};
  assign temp_diff  = {1'b0, temp_prod[28:14]} - hfd_pkg::TEMP_OFFSET;
  assign temp_centi = $signed(temp_diff[14:0]);

  // humidity: (625 * raw) >> 12
  assign hum_prod  = {10'd0, hum_raw} * {16'd0, hfd_pkg::HUM_GAIN};
  assign hum_centi = hum_prod[25:12];

endmodule

`default_nettype wire

// ----- hdl/humidity_temp_frame_decoder.sv -----
// Humidity/temperature frame decoder. Takes the six bytes of a measurement
// frame (temperature msb, lsb, crc, humidity msb, lsb, crc) one per request
// and, after the sixth byte, gives one result: both readings in hundredths
// with status ok, or zeros with status checksum mismatch. A frame_start on a
// partial frame gives a short-frame result and that byte opens a new frame.
// Bytes are taken one per cycle while the result slot is free; a byte passes
// an input register and then the crc step and the conversion multiplies into
// the result register, so a result is registered after its last byte has left
// the input register. While a result waits, one more byte can enter the input
// register; the input then stalls until the result is taken.
// Depends on hfd_pkg, hfd_in_if, hfd_out_if and hfd_scale.
`default_nettype none

module humidity_temp_frame_decoder (
  input  wire logic clk,
  input  wire logic rst,
  hfd_in_if.sink    rx,
  hfd_out_if.source result
);

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;

  // frame state
  hfd_pkg::pos_t byte_position, byte_position_next;
  logic [7:0]    running_crc, running_crc_next;
  logic [15:0]   temp_raw_word, temp_raw_word_next;
  logic [15:0]   hum_raw_word, hum_raw_word_next;
  logic          temp_check_ok, temp_check_ok_next;

  // result register
  logic               res_valid;
  logic signed [14:0] res_temp;
  logic [13:0]        res_hum;
  hfd_pkg::status_t   res_status;

  logic               stage_free;
  logic               step;
  hfd_pkg::pos_t      pos;
  logic [7:0]         crc_base;
  logic [7:0]         crc_upd;
  logic               short_frame;
  logic               emit;
  logic signed [14:0] emit_temp;
  logic [13:0]        emit_hum;
  hfd_pkg::status_t   emit_status;
  logic signed [14:0] scaled_temp;
  logic [13:0]        scaled_hum;

  // handshake: the result slot frees the input register
  assign stage_free = !res_valid || result.ready;
  assign step       = in_valid && stage_free;
  assign rx.ready   = !in_valid || stage_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte  <= rx.rx_byte;
      in_start <= rx.frame_start;
    end
  end

  hfd_scale u_scale (
    .temp_raw   (temp_raw_word),
    .hum_raw    (hum_raw_word),
    .temp_centi (scaled_temp),
    .hum_centi  (scaled_hum)
  );

  // frame sequencing and crc check
  always_comb begin
    short_frame = in_start && (byte_position != hfd_pkg::POS_TEMP_MSB) &&
                  (byte_position <= hfd_pkg::LAST_POS);
    pos = (short_frame || byte_position > hfd_pkg::LAST_POS) ?
          hfd_pkg::POS_TEMP_MSB : byte_position;
    crc_base = (pos == hfd_pkg::POS_TEMP_MSB) ? hfd_pkg::CRC_INIT : running_crc;
    crc_upd  = hfd_pkg::crc8_step(crc_base, in_byte);

    running_crc_next   = crc_upd;
    temp_raw_word_next = temp_raw_word;
    hum_raw_word_next  = hum_raw_word;
    temp_check_ok_next = temp_check_ok;
    byte_position_next = (pos == hfd_pkg::LAST_POS) ? hfd_pkg::POS_TEMP_MSB : pos + 3'd1;

    emit        = short_frame;
    emit_temp   = '0;
    emit_hum    = '0;
    emit_status = hfd_pkg::STATUS_SHORT;

    unique case (pos)
      hfd_pkg::POS_TEMP_MSB: temp_raw_word_next = {in_byte, 8'h00};
      hfd_pkg::POS_TEMP_LSB: temp_raw_word_next = {temp_raw_word[15:8], in_byte};
      hfd_pkg::POS_TEMP_CRC: begin
        temp_check_ok_next = (in_byte == crc_base);
        running_crc_next   = hfd_pkg::CRC_INIT;
      end
      hfd_pkg::POS_HUM_MSB: hum_raw_word_next = {in_byte, 8'h00};
      hfd_pkg::POS_HUM_LSB: hum_raw_word_next = {hum_raw_word[15:8], in_byte};
      default: begin
        emit             = 1'b1;
        running_crc_next = hfd_pkg::CRC_INIT;
        if (temp_check_ok && in_byte == crc_base) begin
          emit_temp   = scaled_temp;
          emit_hum    = scaled_hum;
          emit_status = hfd_pkg::STATUS_OK;
        end else begin
          emit_status = hfd_pkg::STATUS_CRC_ERR;
        end
      end
    endcase
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= hfd_pkg::POS_TEMP_MSB;
      running_crc   <= hfd_pkg::CRC_INIT;
      temp_raw_word <= '0;
      hum_raw_word  <= '0;
      temp_check_ok <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      temp_raw_word <= temp_raw_word_next;
      hum_raw_word  <= hum_raw_word_next;
      temp_check_ok <= temp_check_ok_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (step && emit) begin
      res_temp   <= emit_temp;
      res_hum    <= emit_hum;
      res_status <= emit_status;
    end
  end

  assign result.valid             = res_valid;
  assign result.temperature_centi = res_temp;
  assign result.humidity_centi    = res_hum;
  assign result.frame_status      = res_status;

endmodule

`default_nettype wire
